>>> rtl/hex_ascii_packet_parser_assert.svh
// Assertion macros of the hex ASCII packet parser, used by the hap_back module.
// Each macro expects signals clk and rst in the scope that uses it.
`ifndef HEX_ASCII_PACKET_PARSER_ASSERT_SVH
`define HEX_ASCII_PACKET_PARSER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define HAP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hex ascii packet parser: assertion failed");

// Next-cycle implication, checked outside reset.
`define HAP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hex ascii packet parser: assertion failed");

`endif

>>> rtl/hap_pkg.sv
// Types and constants of the hex ASCII packet parser.
// No dependencies; used by every module of the block.
package hap_pkg;

  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [7:0] START_CHAR     = 8'h53;
  localparam logic [7:0] ALPHA_CHAR     = 8'h41;
  localparam logic [7:0] ALPHA_BASE     = 8'd55;
  localparam logic [7:0] DIGIT_BASE     = 8'h30;
  localparam logic [2:0] SIZE_LAST_POS  = 3'd6;
  localparam logic [2:0] WORD_LAST_POS  = 3'd7;

  typedef enum logic [1:0] {
    REG_PING      = 2'd0,
    REG_WRITE     = 2'd1,
    REG_READ      = 2'd2,
    REG_INTERRUPT = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE    = 3'd0,
    ST_SIZE    = 3'd1,
    ST_COMMAND = 3'd2,
    ST_ADDRESS = 3'd3,
    ST_DATA    = 3'd4
  } parse_state_t;

  typedef enum logic {
    KIND_DATA    = 1'b0,
    KIND_ILLEGAL = 1'b1
  } result_kind_t;

  typedef struct packed {
    logic [31:0] ping_code;
    logic [31:0] write_code;
    logic [31:0] read_code;
    logic [31:0] interrupt_code;
  } cfg_t;

  typedef struct packed {
    logic       start;
    logic [3:0] nib;
  } token_t;

  typedef struct packed {
    result_kind_t kind;
    logic [31:0]  command;
    logic [7:0]   device_addr;
    logic [23:0]  address;
    logic [28:0]  word_count;
    logic [27:0]  word_index;
    logic [31:0]  data_word;
    logic         last_word;
  } result_t;

endpackage

>>> rtl/hap_regs.sv
// Configuration register file of the hex ASCII packet parser, APB-style access.
// Depends on hap_pkg.
module hap_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [hap_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [hap_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [hap_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready,
  output hap_pkg::cfg_t                   cfg
);
  import hap_pkg::*;

  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_PING:      cfg.ping_code      <= pwdata;
        REG_WRITE:     cfg.write_code     <= pwdata;
        REG_READ:      cfg.read_code      <= pwdata;
        REG_INTERRUPT: cfg.interrupt_code <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_PING:      prdata = cfg.ping_code;
      REG_WRITE:     prdata = cfg.write_code;
      REG_READ:      prdata = cfg.read_code;
      REG_INTERRUPT: prdata = cfg.interrupt_code;
      default:       prdata = '0;
    endcase
  end

endmodule

>>> rtl/hap_front.sv
// Front end of the hex ASCII packet parser: accepts bytes and classifies them
// into start marks and hex nibbles. Depends on hap_pkg.
module hap_front (
  input  logic            push,
  input  logic [7:0]      rx_byte,
  input  logic            q_full,
  output logic            q_push,
  output hap_pkg::token_t q_token
);
  import hap_pkg::*;

  logic [7:0] digit_val;

  assign digit_val     = (rx_byte >= ALPHA_CHAR) ? (rx_byte - ALPHA_BASE)
                                                 : (rx_byte - DIGIT_BASE);
  assign q_token.start = (rx_byte == START_CHAR);
  assign q_token.nib   = digit_val[3:0];
  assign q_push        = push && !q_full;

endmodule

>>> rtl/hap_fifo.sv
// Short token queue between front end and parser of the hex ASCII packet parser.
// Depends on hap_pkg.
module hap_fifo #(
  parameter int unsigned FIFO_DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr,
  input  hap_pkg::token_t wdata,
  output logic            full,
  input  logic            rd,
  output hap_pkg::token_t rdata,
  output logic            valid
);
  import hap_pkg::*;

  localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

  token_t           slots [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full  = (count == CNT_W'(FIFO_DEPTH));
  assign valid = (count != '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && valid;
  assign rdata = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

>>> rtl/hap_back.sv
// Parser back end of the hex ASCII packet parser: packet state machine,
// field accumulators and the result output register. Depends on hap_pkg
// and hex_ascii_packet_parser_assert.svh.
module hap_back (
  input  logic             clk,
  input  logic             rst,
  input  hap_pkg::cfg_t    cfg,
  input  logic             tok_valid,
  input  hap_pkg::token_t  tok,
  output logic             tok_pop,
  output logic             res_empty,
  input  logic             res_pop,
  output hap_pkg::result_t res
);
  import hap_pkg::*;
  `include "hex_ascii_packet_parser_assert.svh"

  parse_state_t state;
  parse_state_t state_next;
  logic [2:0]   digit_pos;
  logic [2:0]   digit_pos_next;
  logic [27:0]  size_acc;
  logic [27:0]  size_acc_next;
  logic [31:0]  command_acc;
  logic [31:0]  command_acc_next;
  logic [31:0]  address_acc;
  logic [31:0]  address_acc_next;
  logic [31:0]  data_acc;
  logic [31:0]  data_acc_next;
  logic [28:0]  words_left;
  logic [28:0]  words_left_next;
  logic [27:0]  word_pos;
  logic [27:0]  word_pos_next;
  logic         out_valid;
  logic         res_take;
  logic         advance;
  logic         emit;
  result_t      res_next;

  logic [27:0]  size_shift;
  logic [31:0]  cmd_shift;
  logic [31:0]  cmd_inv;
  logic [31:0]  addr_shift;
  logic [31:0]  data_shift;
  logic         cmd_known;
  logic         cmd_intr;
  logic         cmd_ok;
  logic         digit_done;
  logic         last;
  logic         index_ok;

  assign res_take  = res_pop && out_valid;
  assign advance   = tok_valid && (!out_valid || res_pop);
  assign tok_pop   = advance;
  assign res_empty = !out_valid;

  assign size_shift = {size_acc[23:0], tok.nib};
  assign cmd_shift  = {command_acc[27:0], tok.nib};
  assign cmd_inv    = ~cmd_shift;
  assign addr_shift = {address_acc[27:0], tok.nib};
  assign data_shift = {data_acc[27:0], tok.nib};
  assign cmd_known  = (cmd_inv == cfg.ping_code) || (cmd_inv == cfg.write_code)
                      || (cmd_inv == cfg.read_code);
  assign cmd_intr   = (cmd_shift == cfg.interrupt_code);
  assign cmd_ok     = cmd_known || cmd_intr;
  assign digit_done = (digit_pos == ((state == ST_SIZE) ? SIZE_LAST_POS : WORD_LAST_POS));
  assign last       = (words_left == 29'd1);
  assign index_ok   = ({1'b0, res.word_index} < res.word_count);

  always_comb begin
    state_next = state;
    if (advance) begin
      if (tok.start) begin
        state_next = ST_SIZE;
      end else begin
        case (state)
          ST_IDLE:    state_next = ST_IDLE;
          ST_SIZE:    if (digit_done) state_next = ST_COMMAND;
          ST_COMMAND: if (digit_done) state_next = cmd_ok ? ST_ADDRESS : ST_IDLE;
          ST_ADDRESS: if (digit_done) state_next = ST_DATA;
          ST_DATA:    if (digit_done && last) state_next = ST_IDLE;
          default:    state_next = ST_IDLE;
        endcase
      end
    end
  end

  always_comb begin
    digit_pos_next   = digit_pos;
    size_acc_next    = size_acc;
    command_acc_next = command_acc;
    address_acc_next = address_acc;
    data_acc_next    = data_acc;
    words_left_next  = words_left;
    word_pos_next    = word_pos;
    if (advance) begin
      if (tok.start) begin
        digit_pos_next = '0;
        word_pos_next  = '0;
      end else begin
        case (state)
          ST_SIZE: begin
            size_acc_next  = size_shift;
            digit_pos_next = digit_done ? 3'd0 : digit_pos + 3'd1;
            if (digit_done) begin
              words_left_next = {1'b0, size_shift} + 29'd1;
            end
          end
          ST_COMMAND: begin
            command_acc_next = (digit_done && !cmd_intr) ? cmd_inv : cmd_shift;
            if (digit_done && cmd_known) begin
              command_acc_next = cmd_inv;
            end
            digit_pos_next = digit_pos + 3'd1;
          end
          ST_ADDRESS: begin
            address_acc_next = addr_shift;
            digit_pos_next   = digit_pos + 3'd1;
          end
          ST_DATA: begin
            data_acc_next  = data_shift;
            digit_pos_next = digit_pos + 3'd1;
            if (digit_done) begin
              words_left_next = words_left - 29'd1;
              word_pos_next   = word_pos + 28'd1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    emit     = 1'b0;
    res_next = '0;
    if (advance && !tok.start && digit_done) begin
      case (state)
        ST_COMMAND: begin
          if (!cmd_ok) begin
            emit             = 1'b1;
            res_next.kind    = KIND_ILLEGAL;
            res_next.command = cmd_inv;
          end
        end
        ST_DATA: begin
          emit                 = 1'b1;
          res_next.kind        = KIND_DATA;
          res_next.command     = command_acc;
          res_next.device_addr = address_acc[31:24];
          res_next.address     = address_acc[23:0];
          res_next.word_count  = {1'b0, size_acc} + 29'd1;
          res_next.word_index  = word_pos;
          res_next.data_word   = data_shift;
          res_next.last_word   = last;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      digit_pos <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      digit_pos <= digit_pos_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (res_take) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    size_acc    <= size_acc_next;
    command_acc <= command_acc_next;
    address_acc <= address_acc_next;
    data_acc    <= data_acc_next;
    words_left  <= words_left_next;
    word_pos    <= word_pos_next;
    if (emit) begin
      res <= res_next;
    end
  end

  `HAP_ASSERT_NOW(a_no_overwrite, emit, !out_valid || res_take)
  `HAP_ASSERT_NEXT(a_start_restarts, advance && tok.start, state == ST_SIZE && digit_pos == 3'd0)
  `HAP_ASSERT_NOW(a_data_has_words, state == ST_DATA, words_left != 29'd0)
  `HAP_ASSERT_NOW(a_index_in_range, out_valid && res.kind == KIND_DATA, index_ok)

endmodule

>>> rtl/hex_ascii_packet_parser.sv
// Hex ASCII packet parser: one received byte per push, 'S' restarts a packet, then
// 7 size, 8 command and 8 address hex digits and size+1 data words of 8 digits.
// Sustained rate is one byte per clock while not stalled: a byte enters the token
// queue on the edge it is accepted, the parser consumes one queued byte per clock,
// and a result is then registered in the output register. The parser stalls
// only while a finished result waits in the output register and pop is low; full
// rises once FIFO_DEPTH bytes are backlogged. Registers ping_code, write_code,
// read_code and interrupt_code sit at byte addresses 0, 4, 8 and 12; the received
// command is bit-inverted before it is compared with the first three, and compared
// as received with interrupt_code. Depends on hap_pkg, hap_regs, hap_front,
// hap_fifo and hap_back.
module hex_ascii_packet_parser #(
  parameter int unsigned FIFO_DEPTH = 4
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [hap_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [hap_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [hap_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready,
  input  logic                            push,
  output logic                            full,
  input  logic [7:0]                      rx_byte,
  output logic                            empty,
  input  logic                            pop,
  output logic                            result_kind,
  output logic [31:0]                     command,
  output logic [7:0]                      device_addr,
  output logic [23:0]                     address,
  output logic [28:0]                     word_count,
  output logic [27:0]                     word_index,
  output logic [31:0]                     data_word,
  output logic                            last_word
);
  import hap_pkg::*;

  cfg_t    cfg;
  token_t  q_token;
  token_t  tok;
  logic    q_push;
  logic    tok_valid;
  logic    tok_pop;
  result_t res;

  hap_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  hap_front u_front (
    .push    (push),
    .rx_byte (rx_byte),
    .q_full  (full),
    .q_push  (q_push),
    .q_token (q_token)
  );

  hap_fifo #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .wr    (q_push),
    .wdata (q_token),
    .full  (full),
    .rd    (tok_pop),
    .rdata (tok),
    .valid (tok_valid)
  );

  hap_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .tok_valid (tok_valid),
    .tok       (tok),
    .tok_pop   (tok_pop),
    .res_empty (empty),
    .res_pop   (pop),
    .res       (res)
  );

  assign result_kind = res.kind;
  assign command     = res.command;
  assign device_addr = res.device_addr;
  assign address     = res.address;
  assign word_count  = res.word_count;
  assign word_index  = res.word_index;
  assign data_word   = res.data_word;
  assign last_word   = res.last_word;

endmodule

>>> tb/sv/hex_ascii_packet_parser_test.sv
// Self-checking testbench for hex_ascii_packet_parser: streams ASCII packets through
// the push/full side and checks every popped result against an in-bench parser model.
// Depends on hap_pkg and the hex_ascii_packet_parser RTL.
`timescale 1ns / 1ps

module hex_ascii_packet_parser_test;
  import hap_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 16;
  localparam logic [7:0] LOWER_A = 8'h61;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic        pready;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  rx_byte = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic        result_kind;
  logic [31:0] command;
  logic [7:0]  device_addr;
  logic [23:0] address;
  logic [28:0] word_count;
  logic [27:0] word_index;
  logic [31:0] data_word;
  logic        last_word;

  hex_ascii_packet_parser DUT (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .push(push), .full(full), .rx_byte(rx_byte),
    .empty(empty), .pop(pop),
    .result_kind(result_kind), .command(command), .device_addr(device_addr),
    .address(address), .word_count(word_count), .word_index(word_index),
    .data_word(data_word), .last_word(last_word)
  );

  always #4 clk = ~clk;

  // parser model state and register copy
  logic [31:0]  code_regs [0:3] = '{default: '0};
  parse_state_t pstate = ST_IDLE;
  logic [3:0]   digit_pos = '0;
  logic [27:0]  size_acc = '0;
  logic [31:0]  command_acc = '0;
  logic [31:0]  address_acc = '0;
  logic [31:0]  data_acc = '0;
  logic [28:0]  words_left = '0;
  logic [27:0]  word_pos = '0;

  result_t     parsed_due [$];
  logic [7:0]  rx_stream [$];
  logic [7:0]  pkt_bytes [$];
  int          rx_count = 0;
  int          fail_count = 0;
  int          cycles = 0;
  int          send_idle_pct = 0;
  int          pop_stall_pct = 0;

  function automatic logic [3:0] nibble_of(input logic [7:0] b);
    logic [7:0] v;
    v = (b >= ALPHA_CHAR) ? b - ALPHA_BASE : b - DIGIT_BASE;
    return v[3:0];
  endfunction

  function automatic void parse_rx_byte(input logic [7:0] b);
    logic [3:0]  nib;
    logic [31:0] inv;
    result_t     r;
    nib = nibble_of(b);
    r = '0;
    if (b == START_CHAR) begin
      size_acc = '0;
      command_acc = '0;
      address_acc = '0;
      data_acc = '0;
      words_left = '0;
      word_pos = '0;
      digit_pos = '0;
      pstate = ST_SIZE;
      return;
    end
    case (pstate)
      ST_SIZE: begin
        size_acc = {size_acc[23:0], nib};
        digit_pos = digit_pos + 4'd1;
        if (digit_pos == 4'd7) begin
          words_left = {1'b0, size_acc} + 29'd1;
          digit_pos = '0;
          pstate = ST_COMMAND;
        end
      end
      ST_COMMAND: begin
        command_acc = {command_acc[27:0], nib};
        digit_pos = digit_pos + 4'd1;
        if (digit_pos == 4'd8) begin
          inv = ~command_acc;
          if (inv == code_regs[REG_PING] || inv == code_regs[REG_WRITE] ||
              inv == code_regs[REG_READ]) begin
            command_acc = inv;
            digit_pos = '0;
            pstate = ST_ADDRESS;
          end else if (command_acc == code_regs[REG_INTERRUPT]) begin
            digit_pos = '0;
            pstate = ST_ADDRESS;
          end else begin
            command_acc = inv;
            pstate = ST_IDLE;
            r.kind = KIND_ILLEGAL;
            r.command = inv;
            parsed_due.push_back(r);
          end
        end
      end
      ST_ADDRESS: begin
        address_acc = {address_acc[27:0], nib};
        digit_pos = digit_pos + 4'd1;
        if (digit_pos == 4'd8) begin
          digit_pos = '0;
          data_acc = '0;
          pstate = ST_DATA;
        end
      end
      ST_DATA: begin
        data_acc = {data_acc[27:0], nib};
        digit_pos = digit_pos + 4'd1;
        if (digit_pos == 4'd8) begin
          words_left = words_left - 29'd1;
          r.kind = KIND_DATA;
          r.command = command_acc;
          r.device_addr = address_acc[31:24];
          r.address = address_acc[23:0];
          r.word_count = {1'b0, size_acc} + 29'd1;
          r.word_index = word_pos;
          r.data_word = data_acc;
          r.last_word = (words_left == '0);
          parsed_due.push_back(r);
          if (r.last_word) begin
            pstate = ST_IDLE;
          end else begin
            digit_pos = '0;
            data_acc = '0;
            word_pos = word_pos + 28'd1;
          end
        end
      end
      default: begin
        pstate = ST_IDLE;
      end
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [31:0] exp,
                                      input logic [31:0] act);
    if (exp !== act) begin
      $error("%s: expected %0h, got %0h", name, exp, act);
      fail_count++;
    end
  endfunction

  // driver: one transaction per accepted byte, random gaps between them
  always @(posedge clk) begin : drive_rx
    logic       next_push;
    logic [7:0] next_byte;
    if (rst) begin
      push <= 1'b0;
    end else begin
      next_push = push;
      next_byte = rx_byte;
      if (push && !full) begin
        parse_rx_byte(rx_byte);
        next_push = 1'b0;
      end
      if (!next_push && rx_stream.size() > 0 &&
          $urandom_range(99) >= send_idle_pct) begin
        next_push = 1'b1;
        next_byte = rx_stream.pop_front();
      end
      push <= next_push;
      rx_byte <= next_byte;
    end
  end

  // monitor: compare each popped transaction with the oldest one due
  always @(posedge clk) begin : watch_results
    result_t r;
    if (!rst && pop && !empty) begin
      if (parsed_due.size() == 0) begin
        $error("result with none due: kind %0d command %0h", result_kind, command);
        fail_count++;
      end else begin
        r = parsed_due.pop_front();
        check_field("result_kind", 32'(r.kind), 32'(result_kind));
        check_field("command", r.command, command);
        check_field("device_addr", 32'(r.device_addr), 32'(device_addr));
        check_field("address", 32'(r.address), 32'(address));
        check_field("word_count", 32'(r.word_count), 32'(word_count));
        check_field("word_index", 32'(r.word_index), 32'(word_index));
        check_field("data_word", r.data_word, data_word);
        check_field("last_word", 32'(r.last_word), 32'(last_word));
      end
    end
    pop <= rst ? 1'b0 : ($urandom_range(99) >= pop_stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("hex_ascii_packet_parser_test failed");
      $finish;
    end
  end

  function automatic logic [7:0] char_for(input logic [3:0] v);
    logic [7:0]  b;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 70 || (pick < 85 && v < 4'd10)) begin
      b = (v < 4'd10) ? DIGIT_BASE + {4'd0, v} : ALPHA_BASE + {4'd0, v};
    end else if (pick < 85) begin
      b = LOWER_A + {4'd0, v} - 8'd10;
    end else begin
      do b = 8'($urandom_range(255)); while (b == START_CHAR || nibble_of(b) != v);
    end
    return b;
  endfunction

  task automatic add_hex(input logic [31:0] value, input int ndigits);
    for (int i = ndigits - 1; i >= 0; i--) pkt_bytes.push_back(char_for(value[4*i +: 4]));
  endtask

  task automatic queue_packet(input logic [27:0] size, input logic [31:0] raw_cmd,
                              input logic [31:0] addr, input logic [31:0] first_word,
                              input int n_words, input int cut);
    int keep;
    pkt_bytes.delete();
    pkt_bytes.push_back(START_CHAR);
    add_hex({4'd0, size}, 7);
    add_hex(raw_cmd, 8);
    add_hex(addr, 8);
    for (int w = 0; w < n_words; w++) add_hex((w == 0) ? first_word : $urandom, 8);
    keep = (cut > 0 && cut < pkt_bytes.size()) ? cut : pkt_bytes.size();
    for (int i = 0; i < keep; i++) rx_stream.push_back(pkt_bytes[i]);
    rx_count += keep;
  endtask

  task automatic random_packet();
    logic [7:0]  noise;
    logic [27:0] size;
    logic [31:0] raw_cmd;
    logic [31:0] addr;
    logic [31:0] first;
    reg_idx_t    idx;
    int unsigned pick;
    int unsigned sel;
    int          n_words;
    int          cut;
    if ($urandom_range(99) < 5) begin
      repeat ($urandom_range(1, 3)) begin
        do noise = 8'($urandom); while (noise == START_CHAR);
        rx_stream.push_back(noise);
      end
    end
    pick = $urandom_range(99);
    if (pick < 75) size = 28'($urandom_range(0, 2));
    else if (pick < 95) size = 28'($urandom_range(3, 6));
    else size = $urandom_range(1) ? 28'hFFFFFFF : 28'($urandom);
    n_words = (size > 28'd6) ? $urandom_range(1, 3) : int'(size) + 1;
    sel = $urandom_range(0, 4);
    if (sel < 4) begin
      idx = reg_idx_t'(sel);
      raw_cmd = (idx == REG_INTERRUPT) ? code_regs[idx] : ~code_regs[idx];
    end else begin
      raw_cmd = $urandom;
    end
    pick = $urandom_range(99);
    addr = (pick < 10) ? 32'h0 : (pick < 20) ? 32'hFFFFFFFF : $urandom;
    pick = $urandom_range(99);
    first = (pick < 10) ? 32'h0 : (pick < 20) ? 32'hFFFFFFFF : $urandom;
    cut = ($urandom_range(99) < 10) ? $urandom_range(1, 24 + 8 * n_words) : 0;
    queue_packet(size, raw_cmd, addr, first, n_words, cut);
  endtask

  task automatic apb_access(input logic wr, input reg_idx_t idx, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_codes(input logic [31:0] ping, input logic [31:0] wr_ack,
                           input logic [31:0] rd_resp, input logic [31:0] intr);
    logic [31:0] vals [0:3];
    logic [31:0] rdata;
    vals = '{ping, wr_ack, rd_resp, intr};
    for (int k = 0; k < 4; k++) begin
      apb_access(1'b1, reg_idx_t'(k), vals[k], rdata);
      code_regs[k] = vals[k];
      apb_access(1'b0, reg_idx_t'(k), '0, rdata);
      if (rdata !== vals[k]) begin
        $error("register %0d readback: expected %0h, got %0h", k, vals[k], rdata);
        fail_count++;
      end
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (rx_stream.size() != 0 || push || parsed_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : run_phases
    int          send_pcts [0:3];
    int          pop_pcts [0:3];
    int          target;
    logic [31:0] x;
    send_pcts = '{0, 80, 0, 36};
    pop_pcts = '{0, 0, 80, 36};
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    set_codes(32'h0, 32'hFFFFFFFF, $urandom, $urandom);
    rx_stream.push_back(8'h00);
    rx_stream.push_back(8'hFF);
    rx_stream.push_back(ALPHA_CHAR);
    queue_packet(28'd0, ~code_regs[REG_PING], 32'h0, 32'h0, 1, 0);
    queue_packet(28'd1, ~code_regs[REG_WRITE], 32'hFFFFFFFF, 32'hFFFFFFFF, 2, 0);
    queue_packet(28'd0, ~code_regs[REG_READ], $urandom, $urandom, 1, 0);
    queue_packet(28'd0, code_regs[REG_INTERRUPT], $urandom, $urandom, 1, 0);
    queue_packet(28'd2, 32'h5A5A5A5A, $urandom, $urandom, 3, 0);
    queue_packet(28'd2, ~code_regs[REG_PING], 32'h0, 32'h0, 3, 12);
    queue_packet(28'hFFFFFFF, ~code_regs[REG_WRITE], $urandom, 32'h0, 2, 0);
    target = 200;
    while (rx_count < target) random_packet();
    wait_drained();

    for (int phase = 1; phase < 8; phase++) begin
      x = $urandom;
      case (phase)
        2: set_codes(32'h0, 32'h0, 32'h0, 32'h0);
        3: set_codes(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
        4: set_codes(x, x, $urandom, ~x);
        default: set_codes($urandom, $urandom, $urandom, $urandom);
      endcase
      send_idle_pct = send_pcts[phase % 4];
      pop_stall_pct = pop_pcts[phase % 4];
      target += 160;
      if (phase == 2) begin
        while (rx_count < target - 80) random_packet();
        wait_drained();
      end
      while (rx_count < target) random_packet();
      wait_drained();
    end

    if (fail_count == 0) begin
      $display("hex_ascii_packet_parser_test passed");
    end else begin
      $display("hex_ascii_packet_parser_test failed");
    end
    $finish;
  end

endmodule
